@@ hw/rtl/fsd_pkg.sv @@
package fsd_pkg;

  localparam logic [1:0] ST_PIXEL     = 2'd0;
  localparam logic [1:0] ST_HEADER    = 2'd1;
  localparam logic [1:0] ST_BADMAGIC  = 2'd2;
  localparam logic [1:0] ST_TRUNCATED = 2'd3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] pixel_word;
    logic [31:0] image_width;
    logic [31:0] image_height;
    logic        last_pixel;
  } out_item_t;

  // Work handed from the parser to the result stage.
  // data holds {width, height} for a header, the R, G, B words in [47:0] for a pixel.
  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] data;
    logic        last;
  } cmd_t;

endpackage

@@ hw/rtl/fsd_front.sv @@
module fsd_front
  import fsd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     item_valid,
  input  in_item_t item,
  output logic     cmd_valid,
  output cmd_t     cmd
);

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_PIXELS = 2'd1;
  localparam logic [1:0] PH_ERROR  = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  localparam logic [3:0] HDR_LAST_MAGIC = 4'd7;
  localparam logic [3:0] HDR_LAST_WIDTH = 4'd11;
  localparam logic [3:0] HDR_LAST       = 4'd15;
  localparam logic [3:0] PIX_LAST_RGB   = 4'd5;
  localparam logic [3:0] PIX_LAST       = 4'd7;

  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h66;
      3'd1:    c = 8'h61;
      3'd2:    c = 8'h72;
      3'd3:    c = 8'h62;
      3'd4:    c = 8'h66;
      3'd5:    c = 8'h65;
      3'd6:    c = 8'h6c;
      3'd7:    c = 8'h64;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  logic [1:0]  phase_r, phase_nxt;
  logic [3:0]  byte_idx_r, byte_idx_nxt;
  logic        magic_good_r, magic_good_nxt;
  logic [31:0] width_r, width_nxt;
  logic [31:0] height_r, height_nxt;
  logic [31:0] col_r, col_nxt;
  logic [31:0] row_r, row_nxt;
  logic [47:0] chan_r, chan_nxt;

  logic [32:0] col_inc;
  logic [32:0] row_inc;
  logic        col_wrap;
  logic        row_wrap;

  assign col_inc  = {1'b0, col_r} + 33'd1;
  assign row_inc  = {1'b0, row_r} + 33'd1;
  assign col_wrap = col_inc >= {1'b0, width_r};
  assign row_wrap = row_inc >= {1'b0, height_r};

  always_comb begin
    phase_nxt      = phase_r;
    byte_idx_nxt   = byte_idx_r;
    magic_good_nxt = magic_good_r;
    width_nxt      = width_r;
    height_nxt     = height_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    chan_nxt       = chan_r;
    cmd_valid      = 1'b0;
    cmd            = '0;

    if (item_valid) begin
      if (item.end_of_stream) begin
        phase_nxt      = PH_HEADER;
        byte_idx_nxt   = '0;
        magic_good_nxt = 1'b1;
        width_nxt      = '0;
        height_nxt     = '0;
        col_nxt        = '0;
        row_nxt        = '0;
        chan_nxt       = '0;
        if (phase_r == PH_HEADER || phase_r == PH_PIXELS) begin
          cmd_valid  = 1'b1;
          cmd.status = ST_TRUNCATED;
        end
      end else begin
        case (phase_r)
          PH_HEADER: begin
            if (byte_idx_r <= HDR_LAST_MAGIC) begin
              if (item.in_byte != magic_byte(byte_idx_r[2:0])) begin
                magic_good_nxt = 1'b0;
              end
            end else if (byte_idx_r <= HDR_LAST_WIDTH) begin
              width_nxt = {width_r[23:0], item.in_byte};
            end else begin
              height_nxt = {height_r[23:0], item.in_byte};
            end
            if (byte_idx_r != HDR_LAST) begin
              byte_idx_nxt = byte_idx_r + 4'd1;
            end else begin
              byte_idx_nxt = '0;
              col_nxt      = '0;
              row_nxt      = '0;
              chan_nxt     = '0;
              cmd_valid    = 1'b1;
              if (!magic_good_r) begin
                phase_nxt  = PH_ERROR;
                cmd.status = ST_BADMAGIC;
              end else begin
                cmd.status = ST_HEADER;
                cmd.data   = {width_r, height_nxt};
                if (width_r == '0 || height_nxt == '0) begin
                  phase_nxt = PH_DONE;
                  cmd.last  = 1'b1;
                end else begin
                  phase_nxt = PH_PIXELS;
                end
              end
            end
          end
          PH_PIXELS: begin
            if (byte_idx_r <= PIX_LAST_RGB) begin
              chan_nxt = {chan_r[39:0], item.in_byte};
            end
            if (byte_idx_r != PIX_LAST) begin
              byte_idx_nxt = byte_idx_r + 4'd1;
            end else begin
              byte_idx_nxt = '0;
              chan_nxt     = '0;
              cmd_valid    = 1'b1;
              cmd.status   = ST_PIXEL;
              cmd.data     = {16'd0, chan_r};
              if (col_wrap) begin
                col_nxt = '0;
                if (row_wrap) begin
                  cmd.last  = 1'b1;
                  row_nxt   = '0;
                  phase_nxt = PH_DONE;
                end else begin
                  row_nxt = row_inc[31:0];
                end
              end else begin
                col_nxt = col_inc[31:0];
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HEADER;
      byte_idx_r   <= '0;
      magic_good_r <= 1'b1;
      width_r      <= '0;
      height_r     <= '0;
      col_r        <= '0;
      row_r        <= '0;
      chan_r       <= '0;
    end else begin
      phase_r      <= phase_nxt;
      byte_idx_r   <= byte_idx_nxt;
      magic_good_r <= magic_good_nxt;
      width_r      <= width_nxt;
      height_r     <= height_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      chan_r       <= chan_nxt;
    end
  end

endmodule

@@ hw/rtl/fsd_queue.sv @@
module fsd_queue
  import fsd_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  cmd_t          slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push;
  logic          do_pop;

  assign full       = count_r == CNT_FULL;
  assign head_valid = count_r != '0;
  assign head_data  = slot_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

@@ hw/rtl/fsd_back.sv @@
module fsd_back
  import fsd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      head_valid,
  input  cmd_t      head_data,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  // ceil(v/257) = floor((v+256)/257); x>>8 overshoots the quotient by at most one.
  function automatic logic [7:0] reduce16(input logic [15:0] v);
    logic [16:0] x;
    logic [8:0]  q0;
    logic [16:0] prod;
    logic [8:0]  q;
    x    = {1'b0, v} + 17'd256;
    q0   = x[16:8];
    prod = {q0, 8'd0} + {8'd0, q0};
    q    = (prod > x) ? q0 - 9'd1 : q0;
    return q[7:0];
  endfunction

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  assign pop       = head_valid && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (pop) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt            = '0;
      out_data_nxt.status     = head_data.status;
      out_data_nxt.last_pixel = head_data.last;
      case (head_data.status)
        ST_PIXEL: begin
          out_data_nxt.pixel_word = {reduce16(head_data.data[47:32]),
                                     reduce16(head_data.data[31:16]),
                                     reduce16(head_data.data[15:0]), 8'd0};
        end
        ST_HEADER: begin
          out_data_nxt.image_width  = head_data.data[63:32];
          out_data_nxt.image_height = head_data.data[31:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ hw/rtl/farbfeld_stream_decoder.sv @@
// channel | ports                            | payload
// input   | in_valid, in_stall, in_data      | in_item_t: in_byte, end_of_stream
// output  | out_valid, out_stall, out_data   | out_item_t: status, pixel_word,
//         |                                  |   image_width, image_height, last_pixel
//
// One byte per cycle while in_stall is low; the byte completing a result is registered
// into a queue slot, then into the output register, which drives out_valid and out_data.
// The parser stalls only when the command queue is full.
// rst_n is synchronous; reset leaves the block awaiting a header.
// out_stall backs up into the queue, and then in_stall rises.
module farbfeld_stream_decoder
  import fsd_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic q_full;
  logic accept;
  logic cmd_valid;
  cmd_t cmd;
  logic pop;
  logic head_valid;
  cmd_t head_data;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  fsd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (accept),
    .item       (in_data),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd)
  );

  fsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (cmd_valid),
    .push_data  (cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  fsd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

@@ tb/sv/farbfeld_stream_decoder_tb.sv @@
module farbfeld_stream_decoder_tb
  import fsd_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam string FF_MAGIC = "farbfeld";
  localparam int RANDOM_BYTES = 1080;

  typedef enum logic [1:0] {
    AWAIT_HEADER,
    IN_PIXELS,
    ERROR_IDLE,
    IMAGE_DONE
  } parse_phase_e;

  class image_scoreboard;
    parse_phase_e phase;
    logic [3:0]   idx;
    logic         magic_ok;
    logic [31:0]  wid;
    logic [31:0]  hgt;
    logic [31:0]  col;
    logic [31:0]  row;
    logic [47:0]  chans;
    out_item_t    pending_results[$];
    int           errors;

    function new();
      errors = 0;
      phase = AWAIT_HEADER;
      reset_frame();
    endfunction

    function void reset_frame();
      idx = '0;
      magic_ok = 1'b1;
      wid = '0;
      hgt = '0;
      col = '0;
      row = '0;
      chans = '0;
    endfunction

    function void queue_result(logic [1:0] st, logic [31:0] px, logic [31:0] w,
                               logic [31:0] h, logic last);
      out_item_t r;
      r.status = st;
      r.pixel_word = px;
      r.image_width = w;
      r.image_height = h;
      r.last_pixel = last;
      pending_results.push_back(r);
    endfunction

    function logic [7:0] ceil_div257(logic [15:0] v);
      int unsigned t;
      t = (int'(v) + 256) / 257;
      return t[7:0];
    endfunction

    function void note_byte(in_item_t it);
      logic [7:0]  b;
      logic [31:0] px;
      logic        last;
      b = it.in_byte;
      last = 1'b0;
      if (it.end_of_stream) begin
        if (phase == AWAIT_HEADER || phase == IN_PIXELS)
          queue_result(ST_TRUNCATED, '0, '0, '0, 1'b0);
        phase = AWAIT_HEADER;
        reset_frame();
        return;
      end
      case (phase)
        AWAIT_HEADER: begin
          if (idx < 4'd8) begin
            if (b != FF_MAGIC[idx]) magic_ok = 1'b0;
          end else if (idx < 4'd12) begin
            wid = {wid[23:0], b};
          end else begin
            hgt = {hgt[23:0], b};
          end
          if (idx != 4'd15) begin
            idx = idx + 4'd1;
            return;
          end
          idx = '0;
          col = '0;
          row = '0;
          chans = '0;
          if (!magic_ok) begin
            phase = ERROR_IDLE;
            queue_result(ST_BADMAGIC, '0, '0, '0, 1'b0);
          end else if (wid == 0 || hgt == 0) begin
            phase = IMAGE_DONE;
            queue_result(ST_HEADER, '0, wid, hgt, 1'b1);
          end else begin
            phase = IN_PIXELS;
            queue_result(ST_HEADER, '0, wid, hgt, 1'b0);
          end
        end
        IN_PIXELS: begin
          if (idx < 4'd6) chans = {chans[39:0], b};
          if (idx != 4'd7) begin
            idx = idx + 4'd1;
            return;
          end
          idx = '0;
          px = {ceil_div257(chans[47:32]), ceil_div257(chans[31:16]),
                ceil_div257(chans[15:0]), 8'h00};
          chans = '0;
          if (col + 32'd1 >= wid) begin
            col = '0;
            if (row + 32'd1 >= hgt) begin
              last = 1'b1;
              row = '0;
              phase = IMAGE_DONE;
            end else begin
              row = row + 32'd1;
            end
          end else begin
            col = col + 32'd1;
          end
          queue_result(ST_PIXEL, px, '0, '0, last);
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        $error("result with nothing pending: status %0d", got.status);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("pixel_word", want.pixel_word, got.pixel_word);
      compare_field("image_width", want.image_width, got.image_width);
      compare_field("image_height", want.image_height, got.image_height);
      compare_field("last_pixel", 32'(want.last_pixel), 32'(got.last_pixel));
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  image_scoreboard sb = new();
  int  sent = 0;
  bit  calm = 1'b0;

  farbfeld_stream_decoder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 14);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  task automatic push_item(input in_item_t it);
    while (!calm && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    sb.note_byte(it);
    sent++;
    calm = (sent >= 500 && sent < 800);
    @(negedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b);
    push_item('{in_byte: b, end_of_stream: 1'b0});
  endtask

  task automatic send_eos();
    push_item('{in_byte: 8'($urandom), end_of_stream: 1'b1});
  endtask

  task automatic send_word(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) send_byte(w[8*i +: 8]);
  endtask

  task automatic send_header(input logic [31:0] w, input logic [31:0] h, input bit corrupt);
    int         pos;
    logic [7:0] b;
    pos = $urandom_range(7);
    for (int i = 0; i < 8; i++) begin
      b = FF_MAGIC[i];
      if (corrupt && i == pos) b = b ^ 8'($urandom_range(255, 1));
      send_byte(b);
    end
    send_word(w);
    send_word(h);
  endtask

  task automatic send_pixel(input logic [63:0] rgba);
    for (int i = 7; i >= 0; i--) send_byte(rgba[8*i +: 8]);
  endtask

  function automatic logic [15:0] rand_chan();
    case ($urandom_range(5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'(257 * $urandom_range(255));
      3: return 16'(257 * $urandom_range(254) + 1);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_dim();
    case ($urandom_range(9))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return 32'($urandom_range(1, 3));
    endcase
  endfunction

  task automatic random_stream();
    logic [31:0]     w;
    logic [31:0]     h;
    longint unsigned total;
    int              n;
    int              kind;
    kind = $urandom_range(99);
    w = rand_dim();
    h = rand_dim();
    total = longint'(w) * longint'(h) * 8;
    if (kind < 55) begin
      if (total > 72) begin
        w = 32'($urandom_range(0, 3));
        h = 32'($urandom_range(0, 3));
        total = longint'(w) * longint'(h) * 8;
      end
      send_header(w, h, 1'b0);
      for (longint unsigned i = 0; i < total / 8; i++)
        send_pixel({rand_chan(), rand_chan(), rand_chan(), 16'($urandom)});
      repeat ($urandom_range(2)) send_byte(8'($urandom));
      send_eos();
    end else if (kind < 70) begin
      send_header(w, h, 1'b0);
      if (total > 0) begin
        n = (total - 1 > 30) ? 30 : int'(total - 1);
        repeat ($urandom_range(n)) send_byte(8'($urandom));
      end
      send_eos();
    end else if (kind < 80) begin
      send_header(w, h, 1'b1);
      repeat ($urandom_range(5)) send_byte(8'($urandom));
      send_eos();
    end else if (kind < 90) begin
      n = $urandom_range(15);
      for (int i = 0; i < n; i++)
        send_byte(($urandom_range(3) == 0) ? 8'($urandom) : 8'(FF_MAGIC[i % 8]));
      send_eos();
    end else begin
      repeat ($urandom_range(1, 10))
        push_item('{in_byte: 8'($urandom), end_of_stream: ($urandom_range(3) == 0)});
    end
  endtask

  initial begin
    int start;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_eos();
    send_header(32'd1, 32'd1, 1'b0);
    send_pixel(64'hFFFF_0000_0101_1234);
    send_byte(8'hA5);
    send_eos();
    send_eos();
    send_header(32'd2, 32'd1, 1'b0);
    send_pixel(64'h0100_0102_8080_FFFF);
    send_pixel(64'hFEFF_FF00_0001_0000);
    send_eos();
    send_header(32'd3, 32'd3, 1'b1);
    send_byte(8'hFF);
    send_eos();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_eos();
    send_header(32'hFFFF_FFFF, 32'd0, 1'b0);
    send_byte(8'h55);
    send_eos();
    send_header(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_pixel(64'h0000_FFFF_0100_0000);
    send_byte(8'h12);
    send_eos();

    start = sent;
    while (sent - start < RANDOM_BYTES) random_stream();
    in_valid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
